// ----- sv/cmc_pkg.sv -----
// Shared constants and types for the midpoint circle rasterizer.
// No dependencies; the front, queue, back and core files refer to it by scoped names.
package cmc_pkg;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  localparam int CMC_STEP_BITS = 3;
  localparam logic [CMC_STEP_BITS-1:0] CMC_LAST_OUTLINE = 3'd7;
  localparam logic [CMC_STEP_BITS-1:0] CMC_LAST_FILL    = 3'd3;

  localparam int CMC_QDEPTH    = 2;
  localparam int CMC_QPTR_BITS = $clog2(CMC_QDEPTH);

  typedef struct packed {
    logic empty;
    logic full;
  } cmc_qstat_t;

endpackage

// ----- sv/cmc_in_if.sv -----
// Input channel of the circle rasterizer: start or advance words.
// Depends on nothing; widths follow the core parameters.
interface cmc_in_if #(
  parameter int CB = 16,
  parameter int RB = 12
);
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic                 filled;
  logic signed [CB-1:0] center_x;
  logic signed [CB-1:0] center_y;
  logic        [RB-1:0] radius;

  modport source (output valid, action, filled, center_x, center_y, radius, input ready);
  modport sink   (input valid, action, filled, center_x, center_y, radius, output ready);
endinterface

// ----- sv/cmc_out_if.sv -----
// Result channel of the circle rasterizer: points or horizontal spans.
// Depends on nothing; widths follow the core parameters.
interface cmc_out_if #(
  parameter int CB = 16,
  parameter int RB = 12
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] pt_x;
  logic signed [CB-1:0] pt_y;
  logic        [RB:0]   span_len;
  logic                 last;
  logic                 done_res;

  modport source (output valid, pt_x, pt_y, span_len, last, done_res, input ready);
  modport sink   (input valid, pt_x, pt_y, span_len, last, done_res, output ready);
endinterface

// ----- sv/cmc_front.sv -----
// Front end: accepts start/advance words, holds the midpoint walk state
// and pushes one snapshot per iteration into the queue. Uses cmc_pkg.
module cmc_front #(
  parameter int CB = 16,
  parameter int RB = 12,
  parameter int EW = 2 + 2 * CB + 2 * (RB + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  cmc_in_if.sink              in_ch,
  input  cmc_pkg::cmc_qstat_t q_stat,
  output logic                push,
  output logic [EW-1:0]       push_data
);

  localparam int XW = RB + 2;
  localparam int DW = RB + 4;
  localparam logic signed [DW-1:0] ONE_D = 1;
  localparam logic signed [XW-1:0] ONE_X = 1;

  typedef struct packed {
    logic          fill;
    logic          done;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [RB:0]   x;
    logic [RB:0]   y;
  } entry_t;

  logic                 busy_r, busy_nxt;
  logic                 fill_r, fill_nxt;
  logic [CB-1:0]        cx_r, cx_nxt;
  logic [CB-1:0]        cy_r, cy_nxt;
  logic [RB:0]          wx_r, wx_nxt;
  logic [RB:0]          wy_r, wy_nxt;
  logic signed [DW-1:0] dec_r, dec_nxt;

  logic                 accept;
  logic signed [XW-1:0] x_cur, x_n, y_n;
  logic signed [DW-1:0] x_d, y_d, dec_step;
  logic                 done;
  entry_t               ent;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign x_cur = signed'(XW'(wx_r));
  assign y_n   = signed'(XW'(wy_r)) + ONE_X;
  assign x_n   = dec_r[DW-1] ? x_cur : x_cur - ONE_X;
  assign x_d   = DW'(x_n);
  assign y_d   = DW'(y_n);
  assign dec_step = dec_r[DW-1] ? ((y_d <<< 1) + ONE_D) : ((y_d - x_d + ONE_D) <<< 1);
  assign done  = x_n < y_n;

  assign push = accept && (in_ch.action == cmc_pkg::ACT_ADVANCE) && busy_r;

  always_comb begin
    ent.fill  = fill_r;
    ent.done  = done;
    ent.cx    = cx_r;
    ent.cy    = cy_r;
    ent.x     = wx_r;
    ent.y     = wy_r;
    push_data = ent;
  end

  always_comb begin
    busy_nxt = busy_r;
    fill_nxt = fill_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    wx_nxt   = wx_r;
    wy_nxt   = wy_r;
    dec_nxt  = dec_r;
    if (accept && in_ch.action == cmc_pkg::ACT_START) begin
      busy_nxt = 1'b1;
      fill_nxt = in_ch.filled;
      cx_nxt   = in_ch.center_x;
      cy_nxt   = in_ch.center_y;
      wx_nxt   = (RB + 1)'(in_ch.radius);
      wy_nxt   = '0;
      dec_nxt  = ONE_D - signed'(DW'(in_ch.radius));
    end else if (push) begin
      busy_nxt = !done;
      wx_nxt   = x_n[RB:0];
      wy_nxt   = y_n[RB:0];
      dec_nxt  = dec_r + dec_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fill_r <= 1'b0;
      cx_r   <= '0;
      cy_r   <= '0;
      wx_r   <= '0;
      wy_r   <= '0;
      dec_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fill_r <= fill_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      wx_r   <= wx_nxt;
      wy_r   <= wy_nxt;
      dec_r  <= dec_nxt;
    end
  end

endmodule

// ----- sv/cmc_queue.sv -----
// Short queue of iteration snapshots between front and back end.
// Uses cmc_pkg for depth and status struct.
module cmc_queue #(
  parameter int W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [W-1:0]        push_data,
  input  logic                pop,
  output logic [W-1:0]        head,
  output cmc_pkg::cmc_qstat_t stat
);

  localparam int PB = cmc_pkg::CMC_QPTR_BITS;

  logic [W-1:0]  mem_r [cmc_pkg::CMC_QDEPTH];
  logic [PB-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PB-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PB:0]   count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = count_r == '0;
  assign stat.full  = count_r == (PB + 1)'(cmc_pkg::CMC_QDEPTH);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PB + 1)'(push) - (PB + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/cmc_back.sv -----
// Back end: expands one iteration snapshot into eight points or four
// spans, one word per cycle into an output register unless out_ch.ready stalls it. Uses cmc_pkg.
module cmc_back #(
  parameter int CB = 16,
  parameter int RB = 12,
  parameter int EW = 2 + 2 * CB + 2 * (RB + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [EW-1:0]       head,
  input  cmc_pkg::cmc_qstat_t q_stat,
  output logic                pop,
  cmc_out_if.source           out_ch
);

  localparam int AW = CB + RB + 2;
  localparam int SB = cmc_pkg::CMC_STEP_BITS;

  typedef struct packed {
    logic          fill;
    logic          done;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [RB:0]   x;
    logic [RB:0]   y;
  } entry_t;

  entry_t        cur_r;
  logic          cur_v_r, cur_v_nxt;
  logic [SB-1:0] step_r, step_nxt;
  logic          out_v_r, out_v_nxt;
  logic [CB-1:0] pt_x_r, pt_y_r;
  logic [RB:0]   len_r;
  logic          last_r, done_r;

  logic          emit, fin, swap, neg_a, neg_b;
  logic [SB-1:0] last_step;
  logic [RB:0]   a, b;
  logic [AW-1:0] off_a, off_b;
  logic [RB+1:0] twice_a;
  logic [RB:0]   len_nxt;

  assign last_step = cur_r.fill ? cmc_pkg::CMC_LAST_FILL : cmc_pkg::CMC_LAST_OUTLINE;
  assign emit      = cur_v_r && (!out_v_r || out_ch.ready);
  assign fin       = emit && (step_r == last_step);
  assign pop       = !q_stat.empty && (!cur_v_r || fin);

  assign swap  = cur_r.fill ? step_r[1] : step_r[2];
  assign neg_a = cur_r.fill ? 1'b1 : step_r[0];
  assign neg_b = cur_r.fill ? step_r[0] : step_r[1];
  assign a     = swap ? cur_r.y : cur_r.x;
  assign b     = swap ? cur_r.x : cur_r.y;
  assign off_a = neg_a ? -AW'(a) : AW'(a);
  assign off_b = neg_b ? -AW'(b) : AW'(b);
  assign twice_a = {a, 1'b1};
  assign len_nxt = cur_r.fill ? twice_a[RB:0] : (RB + 1)'(1);

  always_comb begin
    cur_v_nxt = cur_v_r;
    step_nxt  = step_r;
    if (emit) begin
      step_nxt = step_r + 1'b1;
    end
    if (fin) begin
      cur_v_nxt = 1'b0;
    end
    if (pop) begin
      cur_v_nxt = 1'b1;
      step_nxt  = '0;
    end
    out_v_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      step_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      step_r  <= step_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (emit) begin
      pt_x_r <= CB'(AW'(cur_r.cx) + off_a);
      pt_y_r <= CB'(AW'(cur_r.cy) + off_b);
      len_r  <= len_nxt;
      last_r <= step_r == last_step;
      done_r <= (step_r == last_step) && cur_r.done;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.pt_x     = pt_x_r;
  assign out_ch.pt_y     = pt_y_r;
  assign out_ch.span_len = len_r;
  assign out_ch.last     = last_r;
  assign out_ch.done_res = done_r;

endmodule

// ----- sv/midpoint_circle_rasterizer_core.sv -----
// Path: queue entry, then back-end snapshot register, then output register.
// Throughput: one result word per cycle while out_ch.ready does not hold the output register;
// eight words per outline advance, four per fill advance. Start words give no result.
// Input takes a word each cycle while the 2-entry iteration queue has room.
// Reset: synchronous, active low; clears the walk, the queue and the output register.
module midpoint_circle_rasterizer_core #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  cmc_in_if.sink    in_ch,
  cmc_out_if.source out_ch
);

  localparam int EW = 2 + 2 * COORD_BITS + 2 * (RADIUS_BITS + 1);

  cmc_pkg::cmc_qstat_t q_stat;
  logic                q_push, q_pop;
  logic [EW-1:0]       q_in, q_head;

  cmc_front #(.CB(COORD_BITS), .RB(RADIUS_BITS), .EW(EW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_data (q_in)
  );

  cmc_queue #(.W(EW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  cmc_back #(.CB(COORD_BITS), .RB(RADIUS_BITS), .EW(EW)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("queue pop while empty");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> out_ch.last) else $error("done without last");

  a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == !q_stat.full) else $error("input ready out of step with queue");
`endif

endmodule
